// ===== sv/hrf_pkg.sv =====
package hrf_pkg;

  localparam int unsigned METHOD_MAX_DEF = 15;
  localparam int unsigned URI_MAX_DEF    = 255;
  localparam int unsigned HEADER_MAX_DEF = 4095;

  localparam int unsigned LEN_W = 17;
  localparam int unsigned KEY_LEN = 15;
  localparam int unsigned ADDR_W = 3;

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_EXPECT_LENGTH = 3'd0;

  typedef enum logic [2:0] {
    REGION_METHOD = 3'd0,
    REGION_SEP    = 3'd1,
    REGION_URI    = 3'd2,
    REGION_HEADER = 3'd3,
    REGION_BODY   = 3'd4,
    REGION_EXCESS = 3'd5
  } region_e;

  typedef enum logic [1:0] {
    STATUS_BUSY       = 2'd0,
    STATUS_COMPLETE   = 2'd1,
    STATUS_INCOMPLETE = 2'd2,
    STATUS_MALFORMED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    logic [7:0]       byte_out;
    region_e          region;
    status_e          status;
    logic [LEN_W-1:0] length_value;
    logic [3:0]       method_length;
    logic [7:0]       uri_length;
    logic [11:0]      header_length;
  } out_t;

  typedef struct packed {
    logic expect_length;
  } cfg_t;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_C     = 8'h43;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // "\r\n\r\n"
  function automatic logic [7:0] blank_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = CHR_CR;
      2'd1: c = CHR_LF;
      2'd2: c = CHR_CR;
      default: c = CHR_LF;
    endcase
    return c;
  endfunction

  // "Content-Length:"
  function automatic logic [7:0] key_char(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = 8'h43; // C
      4'd1:  c = 8'h6F; // o
      4'd2:  c = 8'h6E; // n
      4'd3:  c = 8'h74; // t
      4'd4:  c = 8'h65; // e
      4'd5:  c = 8'h6E; // n
      4'd6:  c = 8'h74; // t
      4'd7:  c = 8'h2D; // -
      4'd8:  c = 8'h4C; // L
      4'd9:  c = 8'h65; // e
      4'd10: c = 8'h6E; // n
      4'd11: c = 8'h67; // g
      4'd12: c = 8'h74; // t
      4'd13: c = 8'h68; // h
      4'd14: c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/hrf_cfg.sv =====
module hrf_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hrf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hrf_pkg::cfg_t              cfg_o
);
  import hrf_pkg::*;

  logic expect_q, expect_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    expect_d = expect_q;
    if (wr_en && paddr == ADDR_EXPECT_LENGTH) begin
      expect_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b0;
    end else begin
      expect_q <= expect_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_EXPECT_LENGTH) begin
      prdata = {31'd0, expect_q};
    end
  end

  assign cfg_o.expect_length = expect_q;

endmodule

// ===== sv/hrf_core.sv =====
module hrf_core #(
  parameter int unsigned METHOD_MAX = hrf_pkg::METHOD_MAX_DEF,
  parameter int unsigned URI_MAX    = hrf_pkg::URI_MAX_DEF,
  parameter int unsigned HEADER_MAX = hrf_pkg::HEADER_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  hrf_pkg::in_t  item_i,
  input  hrf_pkg::cfg_t cfg_i,
  output hrf_pkg::out_t res_o
);
  import hrf_pkg::*;

  localparam int unsigned MCW = $clog2(METHOD_MAX + 1);
  localparam int unsigned UCW = $clog2(URI_MAX + 1);
  localparam int unsigned HCW = $clog2(HEADER_MAX + 1);

  localparam logic [2:0] PH_METHOD = 3'd0;
  localparam logic [2:0] PH_SEP    = 3'd1;
  localparam logic [2:0] PH_URI    = 3'd2;
  localparam logic [2:0] PH_HEADER = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_EXCESS = 3'd5;

  localparam logic [1:0] DG_NONE = 2'd0;
  localparam logic [1:0] DG_SKIP = 2'd1;
  localparam logic [1:0] DG_READ = 2'd2;
  localparam logic [1:0] DG_DONE = 2'd3;

  logic [2:0]       phase_q, phase_d;
  logic [2:0]       blank_q, blank_d;
  logic [3:0]       key_q, key_d;
  logic [1:0]       dgp_q, dgp_d;
  logic [2:0]       dgc_q, dgc_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic             seen_q, seen_d;
  logic [LEN_W-1:0] body_q, body_d;
  logic [MCW-1:0]   mcnt_q, mcnt_d;
  logic [UCW-1:0]   ucnt_q, ucnt_d;
  logic [HCW-1:0]   hcnt_q, hcnt_d;

  logic [7:0]  b;
  logic        is_sp;
  logic        is_dig;
  logic [3:0]  dig;
  logic        done;
  logic        clear;
  region_e     region;
  status_e     status;

  assign b      = item_i.data_byte;
  assign is_sp  = (b == CHR_SPACE);
  assign is_dig = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign dig    = b[3:0];

  always_comb begin
    phase_d = phase_q;
    blank_d = blank_q;
    key_d   = key_q;
    dgp_d   = dgp_q;
    dgc_d   = dgc_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    body_d  = body_q;
    mcnt_d  = mcnt_q;
    ucnt_d  = ucnt_q;
    hcnt_d  = hcnt_q;
    done    = 1'b0;
    region  = REGION_EXCESS;

    case (phase_q)
      PH_METHOD: begin
        if (is_sp) begin
          region  = REGION_SEP;
          phase_d = PH_SEP;
        end else begin
          region = REGION_METHOD;
          if (mcnt_q < MCW'(METHOD_MAX)) mcnt_d = mcnt_q + 1'b1;
        end
      end
      PH_SEP: begin
        if (is_sp) begin
          region = REGION_SEP;
        end else begin
          region  = REGION_URI;
          phase_d = PH_URI;
          if (ucnt_q < UCW'(URI_MAX)) ucnt_d = ucnt_q + 1'b1;
        end
      end
      PH_URI: begin
        if (is_sp) begin
          region  = REGION_SEP;
          phase_d = PH_HEADER;
        end else begin
          region = REGION_URI;
          if (ucnt_q < UCW'(URI_MAX)) ucnt_d = ucnt_q + 1'b1;
        end
      end
      PH_HEADER: begin
        region = REGION_HEADER;
        if (hcnt_q < HCW'(HEADER_MAX)) hcnt_d = hcnt_q + 1'b1;
        if (blank_q < 3'd4) begin
          if (seen_q) begin
            if (dgp_q == DG_SKIP) begin
              if (is_dig) begin
                acc_d = LEN_W'(dig);
                dgc_d = 3'd1;
                dgp_d = DG_READ;
              end else if (!is_sp) begin
                dgp_d = DG_DONE;
              end
            end else if (dgp_q == DG_READ) begin
              if (is_dig) begin
                // times ten as two shifts
                acc_d = (acc_q << 3) + (acc_q << 1) + LEN_W'(dig);
                dgc_d = dgc_q + 1'b1;
                if (dgc_q + 1'b1 >= 3'd5) dgp_d = DG_DONE;
              end else begin
                dgp_d = DG_DONE;
              end
            end
          end else if (key_q < 4'(KEY_LEN) && b == key_char(key_q)) begin
            key_d = key_q + 1'b1;
            if (key_q + 1'b1 == 4'(KEY_LEN)) begin
              seen_d = 1'b1;
              dgp_d  = DG_SKIP;
            end
          end else begin
            key_d = (b == CHR_C) ? 4'd1 : 4'd0;
          end

          if (b == blank_char(blank_q[1:0])) blank_d = blank_q + 1'b1;
          else blank_d = (b == CHR_CR) ? 3'd1 : 3'd0;

          if (blank_d >= 3'd4 && seen_d) begin
            if (acc_d == '0) begin
              done    = 1'b1;
              phase_d = PH_EXCESS;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        region = REGION_BODY;
        body_d = body_q + 1'b1;
        if (body_d >= acc_q) begin
          done    = 1'b1;
          phase_d = PH_EXCESS;
        end
      end
      default: begin
        region  = REGION_EXCESS;
        phase_d = PH_EXCESS;
      end
    endcase
  end

  always_comb begin
    if (done) begin
      status = STATUS_COMPLETE;
    end else if (!item_i.end_of_data) begin
      status = STATUS_BUSY;
    end else if (phase_d == PH_HEADER) begin
      if (hcnt_d == '0) status = STATUS_MALFORMED;
      else if (blank_d < 3'd4) status = STATUS_INCOMPLETE;
      else status = cfg_i.expect_length ? STATUS_INCOMPLETE : STATUS_COMPLETE;
    end else if (phase_d == PH_BODY) begin
      status = STATUS_INCOMPLETE;
    end else begin
      status = STATUS_MALFORMED;
    end
  end

  assign clear = item_i.end_of_data && (status != STATUS_INCOMPLETE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD;
      blank_q <= '0;
      key_q   <= '0;
      dgp_q   <= DG_NONE;
      dgc_q   <= '0;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      body_q  <= '0;
      mcnt_q  <= '0;
      ucnt_q  <= '0;
      hcnt_q  <= '0;
    end else if (fire_i) begin
      if (clear) begin
        phase_q <= PH_METHOD;
        blank_q <= '0;
        key_q   <= '0;
        dgp_q   <= DG_NONE;
        dgc_q   <= '0;
        acc_q   <= '0;
        seen_q  <= 1'b0;
        body_q  <= '0;
        mcnt_q  <= '0;
        ucnt_q  <= '0;
        hcnt_q  <= '0;
      end else begin
        phase_q <= phase_d;
        blank_q <= blank_d;
        key_q   <= key_d;
        dgp_q   <= dgp_d;
        dgc_q   <= dgc_d;
        acc_q   <= acc_d;
        seen_q  <= seen_d;
        body_q  <= body_d;
        mcnt_q  <= mcnt_d;
        ucnt_q  <= ucnt_d;
        hcnt_q  <= hcnt_d;
      end
    end
  end

  assign res_o.byte_out      = b;
  assign res_o.region        = region;
  assign res_o.status        = status;
  assign res_o.length_value  = seen_d ? acc_d : '0;
  assign res_o.method_length = 4'(mcnt_d);
  assign res_o.uri_length    = 8'(ucnt_d);
  assign res_o.header_length = 12'(hcnt_d);

endmodule

// ===== sv/http_request_head_framer.sv =====
// channel | dir | handshake                   | word
// in      | rx  | in_valid_i / in_stall_o     | data_byte, end_of_data
// out     | tx  | out_valid_o / out_stall_i   | byte, region, status, lengths
// cfg     | rx  | APB, pready tied high       | expect_length at 0x0
//
// One word per cycle sustained while out_stall_i stays low.
// An input register feeds the parse logic, which updates the request
// state as the word moves into the result register.
// Reset clears all request state and expect_length; no clearing pass.
// in_stall_o rises only while both the result and the input register are full.
module http_request_head_framer #(
  parameter int unsigned METHOD_MAX = hrf_pkg::METHOD_MAX_DEF,
  parameter int unsigned URI_MAX    = hrf_pkg::URI_MAX_DEF,
  parameter int unsigned HEADER_MAX = hrf_pkg::HEADER_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hrf_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hrf_pkg::out_t              out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hrf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hrf_pkg::*;

  logic  in_vld_q, in_vld_d;
  in_t   in_q;
  logic  out_vld_q, out_vld_d;
  out_t  out_q;
  logic  adv;
  logic  take;
  cfg_t  cfg;
  out_t  res;

  hrf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hrf_core #(
    .METHOD_MAX (METHOD_MAX),
    .URI_MAX    (URI_MAX),
    .HEADER_MAX (HEADER_MAX)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (adv) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_q <= in_data_i;
    if (adv) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register free");

  a_complete_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STATUS_COMPLETE) |->
      (out_data_o.region == REGION_HEADER || out_data_o.region == REGION_BODY))
    else $error("request complete outside header or body");

  a_body_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.region == REGION_BODY) |-> (out_data_o.length_value != '0))
    else $error("body word without length");
`endif

endmodule
